@@ rtl/euler_quaternion_gravity_removal_core_defines.svh @@
// assertion macros used by the gravity removal queue
`ifndef EULER_QUATERNION_GRAVITY_REMOVAL_CORE_DEFINES_SVH
`define EULER_QUATERNION_GRAVITY_REMOVAL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define EQGR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("eqgr assertion failed");
`define EQGR_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("eqgr forbidden condition seen");
`else
`define EQGR_ASSERT(lbl, clk, rst, prop)
`define EQGR_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ rtl/eqgr_pkg.sv @@
// shared types, constants and tables for the gravity removal block
package eqgr_pkg;

  localparam int AccelWidth  = 16;
  localparam int CordicSteps = 16;
  localparam int AngleWidth  = 24;
  localparam int QuatWidth   = 16;
  localparam int OffsetWidth = 16;
  localparam int CordicWidth = 34;
  localparam int QueueDepth  = 4;

  localparam logic signed [OffsetWidth-1:0] GravityReset = 16'sd4096;

  // angle reduction constants
  localparam logic [24:0] AngleBias    = 25'd8478720;
  localparam logic [39:0] TurnRecip    = 40'd23302;
  localparam logic [26:0] TurnUnits    = 27'd184320;
  localparam logic [17:0] QuarterUnits = 18'd46080;
  localparam logic [29:0] PiFracMul    = 30'd19106;
  localparam logic [29:0] PhaseRound   = 30'd46080;
  localparam logic [31:0] PiIntMul     = 32'd36602;
  localparam logic [37:0] Div45Recip   = 38'd372828;
  localparam logic [20:0] Div45        = 21'd45;

  localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic [31:0] z;
    logic [1:0]  quad;
  } phase_t;

  typedef struct packed {
    logic signed [AccelWidth-1:0] x;
    logic signed [AccelWidth-1:0] y;
    logic signed [AccelWidth-1:0] z;
  } accel_t;

  typedef struct packed {
    phase_t roll;
    phase_t pitch;
    phase_t yaw;
    accel_t acc;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // arctangent of 2^-i in q2.30
  function automatic logic signed [CordicWidth-1:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

@@ rtl/euler_quaternion_gravity_removal_core.sv @@
// top level of the euler angle quaternion gravity removal block
//
// input channel: in_valid / in_stall with roll, pitch, yaw angles (1/256 degree)
// and a q3.12 acceleration; a transaction moves when in_valid is high and
// in_stall is low. output channel: out_valid / out_stall with the rotated,
// saturated acceleration and the q1.14 quaternion, one result per transaction.
// gravity_offset is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, the block does not enforce this. throughput: one
// transaction per cycle, sustained while the receiver does not stall. from input
// accept to out_valid a transaction passes five angle reduction stages, the queue,
// the cordic load register and one register per cordic iteration, then nine stages
// of quaternion, matrix and rotation. when the receiver stalls the back pipeline
// holds, the four entry queue fills and then in_stall rises; no transaction is dropped.
// reset (rst, synchronous) empties both pipelines and the queue and sets
// gravity_offset to one g (4096).
module euler_quaternion_gravity_removal_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic signed [eqgr_pkg::OffsetWidth-1:0] cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [eqgr_pkg::AngleWidth-1:0]  roll_angle,
  input  logic signed [eqgr_pkg::AngleWidth-1:0]  pitch_angle,
  input  logic signed [eqgr_pkg::AngleWidth-1:0]  yaw_angle,
  input  logic signed [eqgr_pkg::AccelWidth-1:0]  accel_in_x,
  input  logic signed [eqgr_pkg::AccelWidth-1:0]  accel_in_y,
  input  logic signed [eqgr_pkg::AccelWidth-1:0]  accel_in_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [eqgr_pkg::AccelWidth-1:0]  accel_out_x,
  output logic signed [eqgr_pkg::AccelWidth-1:0]  accel_out_y,
  output logic signed [eqgr_pkg::AccelWidth-1:0]  accel_out_z,
  output logic signed [eqgr_pkg::QuatWidth-1:0]   quat_w,
  output logic signed [eqgr_pkg::QuatWidth-1:0]   quat_x,
  output logic signed [eqgr_pkg::QuatWidth-1:0]   quat_y,
  output logic signed [eqgr_pkg::QuatWidth-1:0]   quat_z
);
  import eqgr_pkg::*;

  logic signed [OffsetWidth-1:0] gravity_offset;
  logic                          push;
  logic                          pop;
  qitem_t                        push_item;
  qitem_t                        pop_item;
  q_status_t                     q_status;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_offset <= GravityReset;
    end else if (cfg_we) begin
      gravity_offset <= cfg_wdata;
    end
  end

  eqgr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .accel_in_x  (accel_in_x),
    .accel_in_y  (accel_in_y),
    .accel_in_z  (accel_in_z),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  eqgr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (push_item),
    .pop    (pop),
    .dout   (pop_item),
    .status (q_status)
  );

  eqgr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_item         (pop_item),
    .q_status       (q_status),
    .pop            (pop),
    .gravity_offset (gravity_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .accel_out_x    (accel_out_x),
    .accel_out_y    (accel_out_y),
    .accel_out_z    (accel_out_z),
    .quat_w         (quat_w),
    .quat_x         (quat_x),
    .quat_y         (quat_y),
    .quat_z         (quat_z)
  );

endmodule

@@ rtl/eqgr_front.sv @@
// front pipeline: accepts transactions and reduces each angle to quadrant and cordic phase
module eqgr_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [eqgr_pkg::AngleWidth-1:0]  roll_angle,
  input  logic signed [eqgr_pkg::AngleWidth-1:0]  pitch_angle,
  input  logic signed [eqgr_pkg::AngleWidth-1:0]  yaw_angle,
  input  logic signed [eqgr_pkg::AccelWidth-1:0]  accel_in_x,
  input  logic signed [eqgr_pkg::AccelWidth-1:0]  accel_in_y,
  input  logic signed [eqgr_pkg::AccelWidth-1:0]  accel_in_z,
  input  eqgr_pkg::q_status_t                     q_status,
  output logic                                    push,
  output eqgr_pkg::qitem_t                        push_item
);
  import eqgr_pkg::*;

  logic                         en;
  logic [4:0]                   v;
  logic signed [AngleWidth-1:0] ang [3];
  accel_t                       acc [5];

  logic [24:0] s1_p [3];
  logic [6:0]  s1_q [3];
  logic [17:0] s2_r [3];
  logic [1:0]  s3_quad [3];
  logic [18:0] s3_m [3];
  logic [31:0] s3_base [3];
  logic [1:0]  s4_quad [3];
  logic [18:0] s4_m [3];
  logic [31:0] s4_base [3];
  logic [13:0] s4_qd [3];
  phase_t      s5_ph [3];

  logic [24:0] n1_p [3];
  logic [6:0]  n1_q [3];
  logic [17:0] n2_r [3];
  logic [1:0]  n3_quad [3];
  logic [18:0] n3_m [3];
  logic [31:0] n3_base [3];
  logic [13:0] n4_qd [3];
  phase_t      n5_ph [3];

  // handshake toward the queue
  assign en       = !v[4] || !q_status.full;
  assign in_stall = !en;
  assign push     = v[4] && !q_status.full;

  assign ang[0] = roll_angle;
  assign ang[1] = pitch_angle;
  assign ang[2] = yaw_angle;

  // per lane reduction arithmetic
  always_comb begin
    logic [39:0]        prod1;
    logic signed [26:0] rr;
    logic [17:0]        r2;
    logic [29:0]        mfull;
    logic [37:0]        prod4;
    logic signed [20:0] rem;
    logic [13:0]        qf;
    for (int k = 0; k < 3; k++) begin
      // bias to positive, estimate turns with reciprocal
      n1_p[k] = 25'(ang[k]) + AngleBias;
      prod1   = 40'(n1_p[k]) * TurnRecip;
      n1_q[k] = 7'(prod1 >> 32);
      // remainder in one double turn, estimate is at most one high
      rr = $signed({2'b00, s1_p[k]}) - $signed(27'(27'(s1_q[k]) * TurnUnits));
      if (rr[26]) begin
        rr = rr + $signed(TurnUnits);
      end
      n2_r[k] = 18'(rr);
      // quadrant and remainder to radians, split constant
      if (s2_r[k] >= 18'd138240) begin
        n3_quad[k] = 2'd3;
      end else if (s2_r[k] >= 18'd92160) begin
        n3_quad[k] = 2'd2;
      end else if (s2_r[k] >= QuarterUnits) begin
        n3_quad[k] = 2'd1;
      end else begin
        n3_quad[k] = 2'd0;
      end
      r2         = s2_r[k] - 18'(18'(n3_quad[k]) * QuarterUnits);
      mfull      = 30'(r2) * PiFracMul + PhaseRound;
      n3_m[k]    = 19'(mfull >> 11);
      n3_base[k] = 32'(r2) * PiIntMul;
      // divide by 45 through reciprocal
      prod4    = 38'(s3_m[k]) * Div45Recip;
      n4_qd[k] = 14'(prod4 >> 24);
      // correct quotient and finish phase
      rem = $signed({2'b00, s4_m[k]}) - $signed(21'(21'(s4_qd[k]) * Div45));
      qf  = rem[20] ? s4_qd[k] - 14'd1 : s4_qd[k];
      n5_ph[k].z    = s4_base[k] + 32'(qf);
      n5_ph[k].quad = s4_quad[k];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= '{x: accel_in_x, y: accel_in_y, z: accel_in_z};
      for (int s = 1; s < 5; s++) begin
        acc[s] <= acc[s-1];
      end
      for (int k = 0; k < 3; k++) begin
        s1_p[k]    <= n1_p[k];
        s1_q[k]    <= n1_q[k];
        s2_r[k]    <= n2_r[k];
        s3_quad[k] <= n3_quad[k];
        s3_m[k]    <= n3_m[k];
        s3_base[k] <= n3_base[k];
        s4_quad[k] <= s3_quad[k];
        s4_m[k]    <= s3_m[k];
        s4_base[k] <= s3_base[k];
        s4_qd[k]   <= n4_qd[k];
        s5_ph[k]   <= n5_ph[k];
      end
    end
  end

  assign push_item.roll  = s5_ph[0];
  assign push_item.pitch = s5_ph[1];
  assign push_item.yaw   = s5_ph[2];
  assign push_item.acc   = acc[4];

endmodule

@@ rtl/eqgr_queue.sv @@
// short queue between the front and back pipelines
`include "euler_quaternion_gravity_removal_core_defines.svh"
module eqgr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  eqgr_pkg::qitem_t    din,
  input  logic                pop,
  output eqgr_pkg::qitem_t    dout,
  output eqgr_pkg::q_status_t status
);
  import eqgr_pkg::*;

  localparam int PtrW   = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  qitem_t            slots [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  assign status.full  = (count == CountW'(QueueDepth));
  assign status.empty = (count == '0);
  assign dout         = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CountW'(1);
      end else if (pop && !push) begin
        count <= count - CountW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  `EQGR_ASSERT(a_count_range, clk, rst, count <= CountW'(QueueDepth))
  `EQGR_NEVER(a_no_overflow, clk, rst, push && status.full)
  `EQGR_NEVER(a_no_underflow, clk, rst, pop && status.empty)
  `EQGR_ASSERT(a_count_track, clk, rst, (push && !pop) |=> count == $past(count) + CountW'(1))

endmodule

@@ rtl/eqgr_back.sv @@
// back pipeline: cordic lanes, quaternion, rotation matrix, vector rotation, gravity offset and saturation
module eqgr_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  eqgr_pkg::qitem_t                        q_item,
  input  eqgr_pkg::q_status_t                     q_status,
  output logic                                    pop,
  input  logic signed [eqgr_pkg::OffsetWidth-1:0] gravity_offset,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [eqgr_pkg::AccelWidth-1:0]  accel_out_x,
  output logic signed [eqgr_pkg::AccelWidth-1:0]  accel_out_y,
  output logic signed [eqgr_pkg::AccelWidth-1:0]  accel_out_z,
  output logic signed [eqgr_pkg::QuatWidth-1:0]   quat_w,
  output logic signed [eqgr_pkg::QuatWidth-1:0]   quat_x,
  output logic signed [eqgr_pkg::QuatWidth-1:0]   quat_y,
  output logic signed [eqgr_pkg::QuatWidth-1:0]   quat_z
);
  import eqgr_pkg::*;

  localparam int CW    = CordicWidth;
  localparam int ProdW = 32 + AccelWidth;
  localparam int SumW  = ProdW + 2;
  localparam int RndW  = SumW - 28;
  localparam int DiffW = RndW + 1;
  localparam logic signed [DiffW-1:0] AccMax = DiffW'(2**(AccelWidth-1) - 1);
  localparam logic signed [DiffW-1:0] AccMin = -AccMax - DiffW'(1);
  localparam logic signed [31:0]      One28  = 32'sd268435456;

  logic                 en;
  logic [CordicSteps:0] cv;
  logic [8:0]           pv;
  phase_t               ph_in [3];

  logic signed [CW-1:0] cx [3][CordicSteps+1];
  logic signed [CW-1:0] cy [3][CordicSteps+1];
  logic signed [CW-1:0] cz [3][CordicSteps+1];
  logic [1:0]           cq [3][CordicSteps+1];
  accel_t               cacc [CordicSteps+1];

  logic signed [15:0] r_c [3];
  logic signed [15:0] r_s [3];
  accel_t             r_acc;
  logic signed [31:0] qa_p [4];
  logic signed [15:0] qa_cr, qa_sr;
  accel_t             qa_acc;
  logic signed [48:0] qb_s [4];
  accel_t             qb_acc;
  logic signed [15:0] qc_q [4];
  accel_t             qc_acc;
  logic signed [31:0] md_p [9];
  logic signed [15:0] md_q [4];
  accel_t             md_acc;
  logic signed [31:0] me_r [9];
  logic signed [15:0] me_q [4];
  accel_t             me_acc;
  logic signed [ProdW-1:0] mf_p [9];
  logic signed [15:0]      mf_q [4];
  logic signed [RndW-1:0]  mg_o [3];
  logic signed [15:0]      mg_q [4];

  // quaternion part: round q42 sum to q14 and clamp to plus or minus one
  function automatic logic signed [15:0] quat_part(input logic signed [48:0] s);
    logic signed [48:0] t;
    logic signed [20:0] r;
    t = s + 49'sd134217728;
    r = 21'(t >>> 28);
    if (r > 21'sd16384) begin
      return 16'sd16384;
    end else if (r < -21'sd16384) begin
      return -16'sd16384;
    end
    return 16'(r);
  endfunction

  // clamp to the signed accel range
  function automatic logic signed [AccelWidth-1:0] sat(input logic signed [DiffW-1:0] d);
    if (d > AccMax) begin
      return AccelWidth'(AccMax);
    end else if (d < AccMin) begin
      return AccelWidth'(AccMin);
    end
    return AccelWidth'(d);
  endfunction

  // round a rotated sum by 28 bits
  function automatic logic signed [RndW-1:0] rnd28(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] t;
    t = s + SumW'(134217728);
    return RndW'(t >>> 28);
  endfunction

  // one global advance for the whole back pipeline
  assign en        = !out_valid || !out_stall;
  assign pop       = en && !q_status.empty;
  assign out_valid = pv[8];

  assign ph_in[0] = q_item.roll;
  assign ph_in[1] = q_item.pitch;
  assign ph_in[2] = q_item.yaw;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
      pv <= '0;
    end else if (en) begin
      cv <= {cv[CordicSteps-1:0], pop};
      pv <= {pv[7:0], cv[CordicSteps]};
    end
  end

  // cordic load and one rotation per stage
  always_ff @(posedge clk) begin
    if (en) begin
      cacc[0] <= q_item.acc;
      for (int k = 0; k < 3; k++) begin
        cx[k][0] <= CordicGain;
        cy[k][0] <= '0;
        cz[k][0] <= $signed({2'b00, ph_in[k].z});
        cq[k][0] <= ph_in[k].quad;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        cacc[i+1] <= cacc[i];
        for (int k = 0; k < 3; k++) begin
          cq[k][i+1] <= cq[k][i];
          if (!cz[k][i][CW-1]) begin
            cx[k][i+1] <= cx[k][i] - (cy[k][i] >>> i);
            cy[k][i+1] <= cy[k][i] + (cx[k][i] >>> i);
            cz[k][i+1] <= cz[k][i] - atan_q30(i);
          end else begin
            cx[k][i+1] <= cx[k][i] + (cy[k][i] >>> i);
            cy[k][i+1] <= cy[k][i] - (cx[k][i] >>> i);
            cz[k][i+1] <= cz[k][i] + atan_q30(i);
          end
        end
      end
    end
  end

  // round to q14 and restore the quadrant
  always_ff @(posedge clk) begin
    logic signed [CW-1:0] tc;
    logic signed [CW-1:0] ts;
    logic signed [15:0]   c;
    logic signed [15:0]   s;
    if (en) begin
      r_acc <= cacc[CordicSteps];
      for (int k = 0; k < 3; k++) begin
        tc = cx[k][CordicSteps] + CW'(32768);
        ts = cy[k][CordicSteps] + CW'(32768);
        c  = 16'(tc >>> 16);
        s  = 16'(ts >>> 16);
        unique case (cq[k][CordicSteps])
          2'd0: begin r_c[k] <= c;  r_s[k] <= s;  end
          2'd1: begin r_c[k] <= -s; r_s[k] <= c;  end
          2'd2: begin r_c[k] <= -c; r_s[k] <= -s; end
          2'd3: begin r_c[k] <= s;  r_s[k] <= -c; end
          default: begin r_c[k] <= c; r_s[k] <= s; end
        endcase
      end
    end
  end

  // quaternion: pair products, triple sums, round and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      qa_p[0] <= r_c[2] * r_c[1];
      qa_p[1] <= r_s[2] * r_s[1];
      qa_p[2] <= r_s[2] * r_c[1];
      qa_p[3] <= r_c[2] * r_s[1];
      qa_cr   <= r_c[0];
      qa_sr   <= r_s[0];
      qa_acc  <= r_acc;

      qb_s[0] <= 49'(qa_p[0] * qa_cr) + 49'(qa_p[1] * qa_sr);
      qb_s[1] <= 49'(qa_p[0] * qa_sr) - 49'(qa_p[1] * qa_cr);
      qb_s[2] <= 49'(qa_p[2] * qa_sr) + 49'(qa_p[3] * qa_cr);
      qb_s[3] <= 49'(qa_p[2] * qa_cr) - 49'(qa_p[3] * qa_sr);
      qb_acc  <= qa_acc;

      for (int j = 0; j < 4; j++) begin
        qc_q[j] <= quat_part(qb_s[j]);
      end
      qc_acc <= qb_acc;
    end
  end

  // rotation matrix from the quaternion (w x y z in index order)
  always_ff @(posedge clk) begin
    if (en) begin
      md_p[0] <= qc_q[1] * qc_q[1];
      md_p[1] <= qc_q[2] * qc_q[2];
      md_p[2] <= qc_q[3] * qc_q[3];
      md_p[3] <= qc_q[1] * qc_q[2];
      md_p[4] <= qc_q[1] * qc_q[3];
      md_p[5] <= qc_q[2] * qc_q[3];
      md_p[6] <= qc_q[0] * qc_q[1];
      md_p[7] <= qc_q[0] * qc_q[2];
      md_p[8] <= qc_q[0] * qc_q[3];
      md_q    <= qc_q;
      md_acc  <= qc_acc;

      me_r[0] <= One28 - ((md_p[1] + md_p[2]) <<< 1);
      me_r[1] <= (md_p[3] - md_p[8]) <<< 1;
      me_r[2] <= (md_p[4] + md_p[7]) <<< 1;
      me_r[3] <= (md_p[3] + md_p[8]) <<< 1;
      me_r[4] <= One28 - ((md_p[0] + md_p[2]) <<< 1);
      me_r[5] <= (md_p[5] - md_p[6]) <<< 1;
      me_r[6] <= (md_p[4] - md_p[7]) <<< 1;
      me_r[7] <= (md_p[5] + md_p[6]) <<< 1;
      me_r[8] <= One28 - ((md_p[0] + md_p[1]) <<< 1);
      me_q    <= md_q;
      me_acc  <= md_acc;
    end
  end

  // matrix times accel, round, offset and saturate
  always_ff @(posedge clk) begin
    logic signed [DiffW-1:0] dz;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        mf_p[3*r]   <= ProdW'(me_r[3*r])   * ProdW'(me_acc.x);
        mf_p[3*r+1] <= ProdW'(me_r[3*r+1]) * ProdW'(me_acc.y);
        mf_p[3*r+2] <= ProdW'(me_r[3*r+2]) * ProdW'(me_acc.z);
      end
      mf_q <= me_q;

      for (int r = 0; r < 3; r++) begin
        mg_o[r] <= rnd28(SumW'(mf_p[3*r]) + SumW'(mf_p[3*r+1]) + SumW'(mf_p[3*r+2]));
      end
      mg_q <= mf_q;

      dz = DiffW'(mg_o[2]) - DiffW'(gravity_offset);
      accel_out_x <= sat(DiffW'(mg_o[0]));
      accel_out_y <= sat(DiffW'(mg_o[1]));
      accel_out_z <= sat(dz);
      quat_w      <= mg_q[0];
      quat_x      <= mg_q[1];
      quat_y      <= mg_q[2];
      quat_z      <= mg_q[3];
    end
  end

endmodule

@@ tb/gravity_rotation_scoreboard.sv @@
// scoreboard class: predicts rotated acceleration and quaternion per transaction
`timescale 1ns / 100ps

typedef struct packed {
  logic signed [15:0] ax, ay, az, qw, qx, qy, qz;
} rotation_result_t;

class gravity_rotation_scoreboard;

  // arctangent table in q2.30
  static const longint AtanTable[16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  rotation_result_t pending_q[$];
  longint gravity_level;
  int mismatch_count;

  function new();
    gravity_level = 4096;
    mismatch_count = 0;
  endfunction

  function void set_gravity(logic signed [15:0] v);
    gravity_level = v;
  endfunction

  static function longint round_q(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  static function longint limit(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // cosine and sine of half an angle in 1/256 degree units, q14
  static function void half_trig(longint a, output longint co, output longint si);
    longint p, quad, r, z, x, y, dx, dy, c, s;
    p = a % 184320;
    if (p < 0) p += 184320;
    quad = p / 46080;
    r = p - quad * 46080;
    z = (r * 64'sd3373259426 + 46080) / 92160;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTable[i];
      end else begin
        x += dx; y -= dy; z += AtanTable[i];
      end
    end
    c = round_q(x, 16);
    s = round_q(y, 16);
    case (quad)
      0: begin co = c; si = s; end
      1: begin co = -s; si = c; end
      2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  // note an accepted input transaction
  function void note_input(logic signed [23:0] roll, pitch, yaw,
                           logic signed [15:0] ax, ay, az);
    longint cr, sr, cp, sp, cy, sy, qw, qx, qy, qz, ox, oy, oz;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint one28;
    rotation_result_t res;
    one28 = 64'sd1 <<< 28;
    half_trig(roll, cr, sr);
    half_trig(pitch, cp, sp);
    half_trig(yaw, cy, sy);
    qw = limit(round_q(cy * cp * cr + sy * sp * sr, 28), -16384, 16384);
    qx = limit(round_q(cy * cp * sr - sy * sp * cr, 28), -16384, 16384);
    qy = limit(round_q(sy * cp * sr + cy * sp * cr, 28), -16384, 16384);
    qz = limit(round_q(sy * cp * cr - cy * sp * sr, 28), -16384, 16384);
    m00 = one28 - 2 * (qy * qy + qz * qz);
    m01 = 2 * (qx * qy - qz * qw);
    m02 = 2 * (qx * qz + qy * qw);
    m10 = 2 * (qx * qy + qz * qw);
    m11 = one28 - 2 * (qx * qx + qz * qz);
    m12 = 2 * (qy * qz - qx * qw);
    m20 = 2 * (qx * qz - qy * qw);
    m21 = 2 * (qy * qz + qx * qw);
    m22 = one28 - 2 * (qx * qx + qy * qy);
    ox = round_q(m00 * ax + m01 * ay + m02 * az, 28);
    oy = round_q(m10 * ax + m11 * ay + m12 * az, 28);
    oz = round_q(m20 * ax + m21 * ay + m22 * az, 28) - gravity_level;
    res.ax = 16'(limit(ox, -32768, 32767));
    res.ay = 16'(limit(oy, -32768, 32767));
    res.az = 16'(limit(oz, -32768, 32767));
    res.qw = 16'(qw); res.qx = 16'(qx); res.qy = 16'(qy); res.qz = 16'(qz);
    pending_q.push_back(res);
  endfunction

  // compare one output transaction with the oldest prediction
  function void check_result(rotation_result_t got);
    rotation_result_t exp_r;
    if (pending_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected output transaction");
      return;
    end
    exp_r = pending_q.pop_front();
    if (got !== exp_r) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: exp ax %0d ay %0d az %0d q %0d %0d %0d %0d / %s %0d %0d %0d %0d %0d %0d %0d",
                 exp_r.ax, exp_r.ay, exp_r.az, exp_r.qw, exp_r.qx, exp_r.qy, exp_r.qz,
                 "got", got.ax, got.ay, got.az, got.qw, got.qx, got.qy, got.qz);
    end
  endfunction

endclass

@@ tb/tb_top.sv @@
// top level testbench for the gravity removal core
`timescale 1ns / 100ps

module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic signed [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
  logic signed [15:0] accel_in_x = '0, accel_in_y = '0, accel_in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] accel_out_x, accel_out_y, accel_out_z;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

  gravity_rotation_scoreboard rotation_sb = new();
  bit calm_phase = 1'b0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  always #5 clk = ~clk;

  euler_quaternion_gravity_removal_core u_top (.*);

  // output side: random stall and result checking
  always @(posedge clk) begin
    rotation_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.ax = accel_out_x; got.ay = accel_out_y; got.az = accel_out_z;
      got.qw = quat_w; got.qx = quat_x; got.qy = quat_y; got.qz = quat_z;
      rotation_sb.check_result(got);
    end
    out_stall <= calm_phase ? 1'b0 : ($urandom_range(99) < 26);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) timed_out = 1'b1;
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // drive one input transaction, with a random gap first outside the calm phase
  task automatic send_sample(logic signed [23:0] r, p, y, logic signed [15:0] x, yv, z);
    while (!calm_phase && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    roll_angle <= r; pitch_angle <= p; yaw_angle <= y;
    accel_in_x <= x; accel_in_y <= yv; accel_in_z <= z;
    do @(posedge clk); while (in_stall);
    rotation_sb.note_input(r, p, y, x, yv, z);
  endtask

  task automatic send_random_sample();
    logic signed [23:0] a[3];
    logic signed [15:0] v[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: a[i] = 24'($urandom);
        1: a[i] = $signed(24'($urandom_range(184320))) - 24'sd92160;
        2: a[i] = 24'($urandom_range(8)) * 24'sd11520;
        default: a[i] = $signed(24'($urandom_range(2048))) - 24'sd1024;
      endcase
      v[i] = ($urandom_range(3) == 0) ? 16'($urandom) :
             $signed(16'($urandom_range(16384))) - 16'sd8192;
    end
    send_sample(a[0], a[1], a[2], v[0], v[1], v[2]);
  endtask

  // wait until every result is in, then write gravity level
  task automatic write_gravity(logic signed [15:0] g);
    in_valid <= 1'b0;
    while (rotation_sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    rotation_sb.set_gravity(g);
  endtask

  initial begin
    logic signed [15:0] gravity_levels[4];
    gravity_levels = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd4096};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, quadrant boundaries, reset gravity level
    send_sample('0, '0, '0, '0, '0, 16'sd4096);
    send_sample(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
    send_sample(24'sh800000, 24'sh7FFFFF, 24'sh800000, -16'sh8000, 16'sh7FFF, -16'sh8000);
    send_sample(24'sd46080, 24'sd92160, 24'sd138240, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(-24'sd46080, -24'sd92160, 24'sd184320, -16'sh8000, -16'sh8000, -16'sh8000);
    send_sample(24'sd23040, 24'sd23040, 24'sd23040, 16'sh7FFF, 16'sh7FFF, -16'sh8000);
    send_sample(24'sd184319, -24'sd1, 24'sd1, 16'sd4096, 16'sd4096, 16'sd4096);
    send_sample(24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 16'sh5555, 16'shAAAA, 16'sh0F0F);

    for (int ph = 0; ph < 4; ph++) begin
      write_gravity(gravity_levels[ph]);
      calm_phase = (ph == 2);
      for (int n = 0; n < 375; n++) begin
        send_random_sample();
        // sender holds off until the pipeline drains
        if (n == 200) begin
          in_valid <= 1'b0;
          while (rotation_sb.pending_q.size() != 0) @(posedge clk);
        end
      end
      calm_phase = 1'b0;
    end

    in_valid <= 1'b0;
    while (rotation_sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (rotation_sb.mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
